// File: src/ffha_pkg.sv
// ---------------------------------------------------------------------------
// ffha_pkg: shared definitions for the first-fit heap allocator
// Constants, tag and status codes, datapath commands and status bundles.
// ---------------------------------------------------------------------------
package ffha_pkg;

	localparam int unsigned HEAP_GRANULES  = 8192;
	localparam int unsigned PAGE_BYTES     = 4096;
	localparam int unsigned GRANULE_BYTES  = 8;
	localparam int unsigned HEADER_BYTES   = 24;
	localparam int unsigned MAX_PAGES      = 16;
	localparam int unsigned DEFAULT_PAGES  = 16;
	localparam int unsigned RESET_PAGES    = 16;

	localparam int unsigned HDR_GR         = HEADER_BYTES / GRANULE_BYTES;
	localparam int unsigned GRAN_SHIFT     = $clog2(GRANULE_BYTES);
	localparam int unsigned PAGE_GRANULES  = PAGE_BYTES / GRANULE_BYTES;

	localparam int unsigned PAGES_W        = 5;
	localparam int unsigned SIZE_W         = 16;
	localparam int unsigned OFFSET_W       = 16;
	localparam int unsigned STATUS_W       = 3;
	localparam int unsigned TAG_W          = 2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [TAG_W-1:0] {
		TAG_NONE  = 2'd0,
		TAG_FREE  = 2'd1,
		TAG_ALLOC = 2'd2
	} tag_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_FIT    = 3'd1,
		ST_ZERO_SIZE = 3'd2,
		ST_BAD_RANGE = 3'd3,
		ST_BAD_FREE  = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		CMD_NONE     = 5'd0,
		CMD_CLEAR    = 5'd1,
		CMD_INIT     = 5'd2,
		CMD_LOAD     = 5'd3,
		CMD_A_START  = 5'd4,
		CMD_RD_CUR   = 5'd5,
		CMD_A_STEP   = 5'd6,
		CMD_A_HIT    = 5'd7,
		CMD_A_WSPLIT = 5'd8,
		CMD_A_WCUR   = 5'd9,
		CMD_A_LINK   = 5'd10,
		CMD_RD_BLK   = 5'd11,
		CMD_F_MARK   = 5'd12,
		CMD_F_STEP   = 5'd13,
		CMD_F_HIT    = 5'd14,
		CMD_F_WBLK   = 5'd15,
		CMD_F_WPREV  = 5'd16
	} cmd_t;

	typedef struct packed {
		cmd_t    op;
		logic    out_load;
		status_t code;
	} ctl_t;

	typedef struct packed {
		logic is_alloc;
		logic zero_size;
		logic bad_range;
		logic cur_nil;
		logic fits;
		logic split;
		logic tag_alloc;
		logic cur_below_blk;
		logic clear_done;
		logic out_busy;
	} dp_stat_t;

endpackage

// File: src/ffha_ram.sv
// ---------------------------------------------------------------------------
// ffha_ram: generic single-write, single-read memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module ffha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/ffha_dpath.sv
// ---------------------------------------------------------------------------
// ffha_dpath: allocator datapath
// Heap stores, list walk registers, size and range arithmetic, result register.
// ---------------------------------------------------------------------------
module ffha_dpath #(
	parameter int unsigned HEAP_GRANULES = ffha_pkg::HEAP_GRANULES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ffha_pkg::ctl_t                   ctl,
	input  logic                             cfg_we,
	input  logic [ffha_pkg::PAGES_W-1:0]     heap_pages,
	input  logic                             mode,
	input  logic [ffha_pkg::SIZE_W-1:0]      request_size,
	input  logic [ffha_pkg::OFFSET_W-1:0]    user_offset,
	input  logic                             out_stall,
	output ffha_pkg::dp_stat_t               stat,
	output logic                             out_valid,
	output logic [ffha_pkg::OFFSET_W-1:0]    result_offset,
	output logic [ffha_pkg::STATUS_W-1:0]    status
);

	localparam int unsigned AW   = $clog2(HEAP_GRANULES);
	localparam int unsigned GW   = $clog2(HEAP_GRANULES + 1);
	localparam int unsigned CW   = ((GW > ffha_pkg::SIZE_W) ? GW : ffha_pkg::SIZE_W) + 2;
	localparam int unsigned GSH  = ffha_pkg::GRAN_SHIFT;
	localparam int unsigned GRW0 = ffha_pkg::PAGES_W + $clog2(ffha_pkg::PAGE_GRANULES) + 1;
	localparam int unsigned GRW  = (GRW0 > GW + 1) ? GRW0 : GW + 1;
	localparam int unsigned OW0  = GW + GSH + 1;
	localparam int unsigned OW   = (OW0 > ffha_pkg::OFFSET_W) ? OW0 : ffha_pkg::OFFSET_W;
	localparam logic [GW-1:0] NIL = GW'(HEAP_GRANULES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_GRANULES - 1);

	logic [ffha_pkg::PAGES_W-1:0]  pages_q;
	logic [AW-1:0]                 clr_q;
	logic [GW-1:0]                 head_q;
	logic                          mode_q;
	logic [ffha_pkg::SIZE_W-1:0]   size_q;
	logic [ffha_pkg::OFFSET_W-1:0] uoff_q;
	logic [GW-1:0]                 cur_q, prev_q;
	logic [GW-1:0]                 len_cur_q, next_cur_q, len_prev_q, len_blk_q;
	logic [ffha_pkg::OFFSET_W-1:0] off_q;
	logic                          out_valid_q;
	logic [ffha_pkg::OFFSET_W-1:0] res_off_q;
	ffha_pkg::status_t             res_st_q;

	logic [ffha_pkg::PAGES_W-1:0]  pages_eff;
	logic [GRW-1:0]                gran_w;
	logic [GW-1:0]                 granules;
	logic [CW-1:0]                 need_c;
	logic [GW-1:0]                 need_g, nb;
	logic [ffha_pkg::OFFSET_W-1:0] blk_w;
	logic [GW-1:0]                 blk_g;
	logic                          mn, mp, split;
	logic [GW-1:0]                 nb_len, nb_next, link_tgt;
	logic [ffha_pkg::OFFSET_W-1:0] alloc_off;

	logic                          tag_we, len_we, nxt_we;
	logic [AW-1:0]                 waddr, raddr;
	ffha_pkg::tag_t                tag_wd;
	logic [GW-1:0]                 len_wd, nxt_wd;
	logic [ffha_pkg::TAG_W-1:0]    rd_tag;
	logic [GW-1:0]                 rd_len, rd_next;

	// heap size in granules from the page count
	always_comb begin
		pages_eff = pages_q;
		if (pages_q == '0) begin
			pages_eff = ffha_pkg::PAGES_W'(ffha_pkg::DEFAULT_PAGES);
		end
		if (pages_eff > ffha_pkg::PAGES_W'(ffha_pkg::MAX_PAGES)) begin
			pages_eff = ffha_pkg::PAGES_W'(ffha_pkg::MAX_PAGES);
		end
		gran_w = GRW'(pages_eff) * GRW'(ffha_pkg::PAGE_GRANULES);
		granules = (gran_w > GRW'(HEAP_GRANULES)) ? NIL : GW'(gran_w);
	end

	assign need_c = ((CW'(size_q) + CW'(ffha_pkg::GRANULE_BYTES - 1)) >> GSH)
		+ CW'(ffha_pkg::HDR_GR);
	assign need_g = GW'(need_c);
	assign nb     = GW'(CW'(cur_q) + need_c);
	assign split  = (CW'(len_cur_q) >= need_c + CW'(ffha_pkg::HDR_GR + 1))
		&& (CW'(cur_q) + need_c < CW'(NIL));
	assign link_tgt = split ? nb : next_cur_q;
	assign alloc_off = ffha_pkg::OFFSET_W'((OW'(cur_q) << GSH) + OW'(ffha_pkg::HEADER_BYTES));

	assign blk_w = (uoff_q - ffha_pkg::OFFSET_W'(ffha_pkg::HEADER_BYTES)) >> GSH;
	assign blk_g = GW'(blk_w);

	assign mn = (cur_q != NIL) && (CW'(blk_g) + CW'(len_blk_q) == CW'(cur_q));
	assign mp = (prev_q != NIL) && (CW'(prev_q) + CW'(len_prev_q) == CW'(blk_g));
	assign nb_len  = len_blk_q + (mn ? len_cur_q : '0);
	assign nb_next = mn ? next_cur_q : cur_q;

	always_comb begin
		stat.is_alloc      = (mode_q == ffha_pkg::MODE_ALLOC);
		stat.zero_size     = (size_q == '0);
		stat.bad_range     = (uoff_q[GSH-1:0] != '0)
			|| (uoff_q < ffha_pkg::OFFSET_W'(ffha_pkg::HEADER_BYTES))
			|| (CW'(blk_w) >= CW'(granules));
		stat.cur_nil       = (cur_q == NIL);
		stat.fits          = (CW'(rd_len) >= need_c);
		stat.split         = split;
		stat.tag_alloc     = (ffha_pkg::tag_t'(rd_tag) == ffha_pkg::TAG_ALLOC);
		stat.cur_below_blk = (cur_q < blk_g);
		stat.clear_done    = (clr_q == LAST_ADDR);
		stat.out_busy      = out_valid_q && out_stall;
	end

	// memory port steering per command
	always_comb begin
		tag_we = 1'b0;
		len_we = 1'b0;
		nxt_we = 1'b0;
		waddr  = '0;
		raddr  = '0;
		tag_wd = ffha_pkg::TAG_NONE;
		len_wd = '0;
		nxt_wd = '0;
		unique case (ctl.op)
			ffha_pkg::CMD_CLEAR: begin
				tag_we = 1'b1;
				waddr  = clr_q;
			end
			ffha_pkg::CMD_INIT: begin
				tag_we = 1'b1;
				len_we = 1'b1;
				nxt_we = 1'b1;
				tag_wd = ffha_pkg::TAG_FREE;
				len_wd = granules;
				nxt_wd = NIL;
			end
			ffha_pkg::CMD_RD_CUR: raddr = cur_q[AW-1:0];
			ffha_pkg::CMD_RD_BLK: raddr = blk_g[AW-1:0];
			ffha_pkg::CMD_A_WSPLIT: begin
				tag_we = 1'b1;
				len_we = 1'b1;
				nxt_we = 1'b1;
				waddr  = nb[AW-1:0];
				tag_wd = ffha_pkg::TAG_FREE;
				len_wd = len_cur_q - need_g;
				nxt_wd = next_cur_q;
			end
			ffha_pkg::CMD_A_WCUR: begin
				tag_we = 1'b1;
				len_we = split;
				nxt_we = 1'b1;
				waddr  = cur_q[AW-1:0];
				tag_wd = ffha_pkg::TAG_ALLOC;
				len_wd = need_g;
				nxt_wd = NIL;
			end
			ffha_pkg::CMD_A_LINK: begin
				nxt_we = (prev_q != NIL);
				waddr  = prev_q[AW-1:0];
				nxt_wd = link_tgt;
			end
			ffha_pkg::CMD_F_MARK: begin
				tag_we = 1'b1;
				waddr  = blk_g[AW-1:0];
				tag_wd = ffha_pkg::TAG_FREE;
			end
			ffha_pkg::CMD_F_WBLK: begin
				len_we = 1'b1;
				nxt_we = 1'b1;
				waddr  = blk_g[AW-1:0];
				len_wd = nb_len;
				nxt_wd = nb_next;
			end
			ffha_pkg::CMD_F_WPREV: begin
				len_we = (prev_q != NIL) && mp;
				nxt_we = (prev_q != NIL);
				waddr  = prev_q[AW-1:0];
				len_wd = len_prev_q + nb_len;
				nxt_wd = mp ? nb_next : blk_g;
			end
			default: ;
		endcase
	end

	ffha_ram #(.WIDTH(ffha_pkg::TAG_W), .DEPTH(HEAP_GRANULES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (waddr),
		.wdata (tag_wd),
		.raddr (raddr),
		.rdata (rd_tag)
	);

	ffha_ram #(.WIDTH(GW), .DEPTH(HEAP_GRANULES)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (waddr),
		.wdata (len_wd),
		.raddr (raddr),
		.rdata (rd_len)
	);

	ffha_ram #(.WIDTH(GW), .DEPTH(HEAP_GRANULES)) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (waddr),
		.wdata (nxt_wd),
		.raddr (raddr),
		.rdata (rd_next)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q     <= ffha_pkg::PAGES_W'(ffha_pkg::RESET_PAGES);
			clr_q       <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pages_q <= heap_pages;
				clr_q   <= '0;
			end else if (ctl.op == ffha_pkg::CMD_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.op == ffha_pkg::CMD_INIT) begin
				head_q <= '0;
			end else if (ctl.op == ffha_pkg::CMD_A_LINK && prev_q == NIL) begin
				head_q <= link_tgt;
			end else if (ctl.op == ffha_pkg::CMD_F_WPREV && prev_q == NIL) begin
				head_q <= blk_g;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (ctl.op) inside
			ffha_pkg::CMD_LOAD: begin
				mode_q <= mode;
				size_q <= request_size;
				uoff_q <= user_offset;
				off_q  <= '0;
			end
			ffha_pkg::CMD_A_START: begin
				cur_q  <= head_q;
				prev_q <= NIL;
			end
			ffha_pkg::CMD_A_STEP: begin
				prev_q <= cur_q;
				cur_q  <= rd_next;
			end
			ffha_pkg::CMD_A_HIT, ffha_pkg::CMD_F_HIT: begin
				len_cur_q  <= rd_len;
				next_cur_q <= rd_next;
			end
			ffha_pkg::CMD_A_LINK: off_q <= alloc_off;
			ffha_pkg::CMD_F_MARK: begin
				len_blk_q <= rd_len;
				cur_q     <= head_q;
				prev_q    <= NIL;
			end
			ffha_pkg::CMD_F_STEP: begin
				prev_q     <= cur_q;
				len_prev_q <= rd_len;
				cur_q      <= rd_next;
			end
			default: ;
		endcase
		if (ctl.out_load) begin
			res_off_q <= (ctl.code == ffha_pkg::ST_OK) ? off_q : '0;
			res_st_q  <= ctl.code;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_offset = res_off_q;
	assign status        = res_st_q;

`ifndef SYNTH
	// the free list is address ordered, so every walk step moves forward
	a_walk_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == ffha_pkg::CMD_A_STEP || ctl.op == ffha_pkg::CMD_F_STEP)
		|=> (cur_q > prev_q))
		else $error("free list walk did not advance in address");

	a_fail_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_load && ctl.code != ffha_pkg::ST_OK) |=> (result_offset == '0))
		else $error("failed request returned a nonzero offset");
`endif

endmodule

// File: src/ffha_ctrl.sv
// ---------------------------------------------------------------------------
// ffha_ctrl: allocator sequencer
// Steps allocate and free requests through the datapath, at most one command a cycle.
// ---------------------------------------------------------------------------
module ffha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               in_valid,
	output logic               in_stall,
	input  ffha_pkg::dp_stat_t stat,
	output ffha_pkg::ctl_t     ctl
);

	typedef enum logic [15:0] {
		S_CLEAR    = 16'h0001,
		S_INIT     = 16'h0002,
		S_IDLE     = 16'h0004,
		S_DECODE   = 16'h0008,
		S_A_RD     = 16'h0010,
		S_A_EVAL   = 16'h0020,
		S_A_WSPLIT = 16'h0040,
		S_A_WCUR   = 16'h0080,
		S_A_LINK   = 16'h0100,
		S_F_TAG    = 16'h0200,
		S_F_WALK   = 16'h0400,
		S_F_WEVAL  = 16'h0800,
		S_F_CEVAL  = 16'h1000,
		S_F_WBLK   = 16'h2000,
		S_F_WPREV  = 16'h4000,
		S_RESP     = 16'h8000
	} state_t;

	state_t            state_q, state_d;
	ffha_pkg::status_t code_q, code_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		code_d       = code_q;
		ctl.op       = ffha_pkg::CMD_NONE;
		ctl.out_load = 1'b0;
		ctl.code     = code_q;
		unique case (state_q)
			S_CLEAR: begin
				ctl.op = ffha_pkg::CMD_CLEAR;
				if (stat.clear_done) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				ctl.op  = ffha_pkg::CMD_INIT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					ctl.op  = ffha_pkg::CMD_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_alloc) begin
					if (stat.zero_size) begin
						code_d  = ffha_pkg::ST_ZERO_SIZE;
						state_d = S_RESP;
					end else begin
						ctl.op  = ffha_pkg::CMD_A_START;
						state_d = S_A_RD;
					end
				end else if (stat.bad_range) begin
					code_d  = ffha_pkg::ST_BAD_RANGE;
					state_d = S_RESP;
				end else begin
					ctl.op  = ffha_pkg::CMD_RD_BLK;
					state_d = S_F_TAG;
				end
			end
			S_A_RD: begin
				if (stat.cur_nil) begin
					code_d  = ffha_pkg::ST_NO_FIT;
					state_d = S_RESP;
				end else begin
					ctl.op  = ffha_pkg::CMD_RD_CUR;
					state_d = S_A_EVAL;
				end
			end
			S_A_EVAL: begin
				if (stat.fits) begin
					ctl.op  = ffha_pkg::CMD_A_HIT;
					state_d = S_A_WSPLIT;
				end else begin
					ctl.op  = ffha_pkg::CMD_A_STEP;
					state_d = S_A_RD;
				end
			end
			S_A_WSPLIT: begin
				if (stat.split) begin
					ctl.op = ffha_pkg::CMD_A_WSPLIT;
				end
				state_d = S_A_WCUR;
			end
			S_A_WCUR: begin
				ctl.op  = ffha_pkg::CMD_A_WCUR;
				state_d = S_A_LINK;
			end
			S_A_LINK: begin
				ctl.op  = ffha_pkg::CMD_A_LINK;
				code_d  = ffha_pkg::ST_OK;
				state_d = S_RESP;
			end
			S_F_TAG: begin
				if (stat.tag_alloc) begin
					ctl.op  = ffha_pkg::CMD_F_MARK;
					state_d = S_F_WALK;
				end else begin
					code_d  = ffha_pkg::ST_BAD_FREE;
					state_d = S_RESP;
				end
			end
			S_F_WALK: begin
				if (stat.cur_nil) begin
					state_d = S_F_WBLK;
				end else begin
					ctl.op  = ffha_pkg::CMD_RD_CUR;
					state_d = stat.cur_below_blk ? S_F_WEVAL : S_F_CEVAL;
				end
			end
			S_F_WEVAL: begin
				ctl.op  = ffha_pkg::CMD_F_STEP;
				state_d = S_F_WALK;
			end
			S_F_CEVAL: begin
				ctl.op  = ffha_pkg::CMD_F_HIT;
				state_d = S_F_WBLK;
			end
			S_F_WBLK: begin
				ctl.op  = ffha_pkg::CMD_F_WBLK;
				state_d = S_F_WPREV;
			end
			S_F_WPREV: begin
				ctl.op  = ffha_pkg::CMD_F_WPREV;
				code_d  = ffha_pkg::ST_OK;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
		if (cfg_we) begin
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ffha_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

`ifndef SYNTH
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == S_CLEAR))
		else $error("register write did not restart the heap clear");

	a_clear_to_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && stat.clear_done && !cfg_we) |=> (state_q == S_INIT))
		else $error("heap clear did not finish with init");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !cfg_we) |=> (state_q == S_DECODE))
		else $error("accepted request was not decoded");
`endif

endmodule

// File: src/first_fit_heap_allocator_unit.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator with coalescing
// Address-ordered free list in three block stores; allocate and free requests.
// ---------------------------------------------------------------------------
// Throughput: one request at a time; each visited free block costs one store read.
// Reset and every heap_pages write run a tag clear over all HEAP_GRANULES entries
//   plus an init step, during which no request is taken.
module first_fit_heap_allocator_unit #(
	parameter int unsigned HEAP_GRANULES = ffha_pkg::HEAP_GRANULES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ffha_pkg::PAGES_W-1:0]  heap_pages,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [ffha_pkg::SIZE_W-1:0]   request_size,
	input  logic [ffha_pkg::OFFSET_W-1:0] user_offset,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ffha_pkg::OFFSET_W-1:0] result_offset,
	output logic [ffha_pkg::STATUS_W-1:0] status
);

	ffha_pkg::ctl_t     ctl;
	ffha_pkg::dp_stat_t stat;
	logic               cfg_we;

	// the register transfer is always taken; it restarts the heap clear
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// the result register sits in the datapath, so a waiting result does not
	// hold off the next request transfer
	ffha_dpath #(.HEAP_GRANULES(HEAP_GRANULES)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cfg_we        (cfg_we),
		.heap_pages    (heap_pages),
		.mode          (mode),
		.request_size  (request_size),
		.user_offset   (user_offset),
		.out_stall     (out_stall),
		.stat          (stat),
		.out_valid     (out_valid),
		.result_offset (result_offset),
		.status        (status)
	);

endmodule

// File: verif/first_fit_heap_allocator_unit_test.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_unit_test: self-checking bench for the heap allocator
// Drives allocate and free requests and heap_pages writes, predicts every
// result with a behavioral heap and free list, and compares each transfer.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_unit_test;

	localparam int unsigned CYCLE_LIMIT = 6000000;
	localparam int unsigned NIL         = ffha_pkg::HEAP_GRANULES;

	typedef struct {
		logic [ffha_pkg::OFFSET_W-1:0] offset;
		ffha_pkg::status_t             code;
	} alloc_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [ffha_pkg::PAGES_W-1:0]  heap_pages;
	logic                          in_valid;
	logic                          in_stall;
	logic                          mode;
	logic [ffha_pkg::SIZE_W-1:0]   request_size;
	logic [ffha_pkg::OFFSET_W-1:0] user_offset;
	logic                          out_valid;
	logic                          out_stall;
	logic [ffha_pkg::OFFSET_W-1:0] result_offset;
	logic [ffha_pkg::STATUS_W-1:0] status;

	// Behavioral heap: tags, block lengths, free-list links, list head.
	ffha_pkg::tag_t tag_mem [ffha_pkg::HEAP_GRANULES];
	int unsigned    len_mem [ffha_pkg::HEAP_GRANULES];
	int unsigned    link_mem[ffha_pkg::HEAP_GRANULES];
	int unsigned    list_head;
	int unsigned    pages_reg;

	alloc_result_t  pending_results[$];
	int unsigned    live_offsets[$];   // user areas that should still be allocated
	int unsigned    stale_offsets[$];  // freed or invalidated user areas

	int unsigned cycles;
	int unsigned errors;
	int unsigned n_items, n_allocs_ok, n_frees_ok, n_rejects, n_cfg;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int          hold_cycles;

	first_fit_heap_allocator_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.heap_pages   (heap_pages),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.request_size (request_size),
		.user_offset  (user_offset),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_offset(result_offset),
		.status       (status)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: a long hold-off wins over the random stall.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall   <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: offset %0d status %0d",
					result_offset, status);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_offset !== exp_r.offset) begin
					$error("result_offset: expected %0d, got %0d", exp_r.offset,
						result_offset);
					errors++;
				end
				if (status !== exp_r.code) begin
					$error("status: expected %0d, got %0d", exp_r.code, status);
					errors++;
				end
			end
		end
	end

	// ---------------- heap prediction ----------------

	function automatic int unsigned heap_size_granules();
		int unsigned p;
		int unsigned g;
		p = pages_reg;
		if (p == 0) p = ffha_pkg::DEFAULT_PAGES;
		if (p > ffha_pkg::MAX_PAGES) p = ffha_pkg::MAX_PAGES;
		g = p * ffha_pkg::PAGE_BYTES / ffha_pkg::GRANULE_BYTES;
		if (g > ffha_pkg::HEAP_GRANULES) g = ffha_pkg::HEAP_GRANULES;
		return g;
	endfunction

	function void heap_reinit();
		for (int i = 0; i < ffha_pkg::HEAP_GRANULES; i++) begin
			tag_mem[i]  = ffha_pkg::TAG_NONE;
			len_mem[i]  = 0;
			link_mem[i] = 0;
		end
		tag_mem[0]  = ffha_pkg::TAG_FREE;
		len_mem[0]  = heap_size_granules();
		link_mem[0] = NIL;
		list_head   = 0;
	endfunction

	function void relink(int unsigned prev, int unsigned target);
		if (prev == NIL) list_head = target;
		else link_mem[prev] = target;
	endfunction

	// First fit over the address-ordered free list, splitting when the tail
	// can hold a header plus one granule.
	function alloc_result_t predict_alloc(int unsigned size);
		alloc_result_t r;
		int unsigned need, prev, cur, steps, blen, nb;
		r.offset = '0;
		r.code   = ffha_pkg::ST_NO_FIT;
		if (size == 0) begin
			r.code = ffha_pkg::ST_ZERO_SIZE;
			return r;
		end
		need  = (size + ffha_pkg::GRANULE_BYTES - 1) / ffha_pkg::GRANULE_BYTES
			+ ffha_pkg::HDR_GR;
		prev  = NIL;
		cur   = list_head;
		steps = 0;
		while (cur < NIL && steps < ffha_pkg::HEAP_GRANULES) begin
			blen = len_mem[cur];
			if (blen >= need) begin
				nb = cur + need;
				if (blen >= need + ffha_pkg::HDR_GR + 1 && nb < NIL) begin
					len_mem[nb]  = blen - need;
					tag_mem[nb]  = ffha_pkg::TAG_FREE;
					link_mem[nb] = link_mem[cur];
					len_mem[cur] = need;
					relink(prev, nb);
				end else begin
					relink(prev, link_mem[cur]);
				end
				tag_mem[cur]  = ffha_pkg::TAG_ALLOC;
				link_mem[cur] = NIL;
				r.offset = ffha_pkg::OFFSET_W'(cur * ffha_pkg::GRANULE_BYTES
					+ ffha_pkg::HEADER_BYTES);
				r.code   = ffha_pkg::ST_OK;
				return r;
			end
			prev = cur;
			cur  = link_mem[cur];
			steps++;
		end
		return r;
	endfunction

	// Range and tag checks, address-ordered insert, merge with both neighbors.
	function alloc_result_t predict_free(int unsigned uoff);
		alloc_result_t r;
		int unsigned blk, prev, cur, steps;
		r.offset = '0;
		r.code   = ffha_pkg::ST_OK;
		if (uoff % ffha_pkg::GRANULE_BYTES != 0 || uoff < ffha_pkg::HEADER_BYTES) begin
			r.code = ffha_pkg::ST_BAD_RANGE;
			return r;
		end
		blk = (uoff - ffha_pkg::HEADER_BYTES) / ffha_pkg::GRANULE_BYTES;
		if (blk >= heap_size_granules()) begin
			r.code = ffha_pkg::ST_BAD_RANGE;
			return r;
		end
		if (tag_mem[blk] != ffha_pkg::TAG_ALLOC) begin
			r.code = ffha_pkg::ST_BAD_FREE;
			return r;
		end
		tag_mem[blk] = ffha_pkg::TAG_FREE;
		prev  = NIL;
		cur   = list_head;
		steps = 0;
		while (cur < NIL && cur < blk && steps < ffha_pkg::HEAP_GRANULES) begin
			prev = cur;
			cur  = link_mem[cur];
			steps++;
		end
		if (cur > NIL) cur = NIL;
		link_mem[blk] = cur;
		relink(prev, blk);
		if (cur != NIL && blk + len_mem[blk] == cur) begin
			len_mem[blk]  += len_mem[cur];
			link_mem[blk]  = link_mem[cur];
		end
		if (prev != NIL && prev + len_mem[prev] == blk) begin
			len_mem[prev]  += len_mem[blk];
			link_mem[prev]  = link_mem[blk];
		end
		return r;
	endfunction

	// ---------------- drivers ----------------

	// Offer one request; predict it at the transfer edge. Valid stays high
	// on return so back-to-back requests need no gap.
	task automatic issue_request(logic m, logic [ffha_pkg::SIZE_W-1:0] sz,
		logic [ffha_pkg::OFFSET_W-1:0] uo);
		alloc_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		request_size <= sz;
		user_offset  <= uo;
		do @(posedge clk); while (in_stall);
		n_items++;
		if (m == ffha_pkg::MODE_ALLOC) r = predict_alloc(sz);
		else r = predict_free(uo);
		pending_results.push_back(r);
		if (r.code == ffha_pkg::ST_OK && m == ffha_pkg::MODE_ALLOC) begin
			n_allocs_ok++;
			live_offsets.push_back(r.offset);
		end else if (r.code == ffha_pkg::ST_OK) begin
			n_frees_ok++;
		end else begin
			n_rejects++;
		end
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain_results();
		release_input();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write heap_pages only with the block idle; every earlier block goes stale.
	task automatic write_pages(int unsigned v);
		drain_results();
		@(negedge clk);
		cfg_valid  <= 1'b1;
		heap_pages <= ffha_pkg::PAGES_W'(v);
		do @(posedge clk); while (!cfg_ready);
		pages_reg = v;
		heap_reinit();
		n_cfg++;
		foreach (live_offsets[i]) stale_offsets.push_back(live_offsets[i]);
		live_offsets.delete();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic free_live(int unsigned idx);
		int unsigned off;
		off = live_offsets[idx];
		live_offsets.delete(idx);
		stale_offsets.push_back(off);
		if (stale_offsets.size() > 64) void'(stale_offsets.pop_front());
		issue_request(ffha_pkg::MODE_FREE, ffha_pkg::SIZE_W'($urandom),
			ffha_pkg::OFFSET_W'(off));
	endtask

	task automatic random_item();
		int unsigned pick, sz;
		pick = $urandom_range(99);
		if (live_offsets.size() > 48 && pick < 50) pick = 60;
		if (pick < 50) begin
			case ($urandom_range(9))
				0:       sz = $urandom_range(65535);
				1:       sz = $urandom_range(16000, 1);
				2, 3:    sz = $urandom_range(2048, 1);
				default: sz = $urandom_range(128, 1);
			endcase
			if ($urandom_range(49) == 0) sz = 0;
			issue_request(ffha_pkg::MODE_ALLOC, ffha_pkg::SIZE_W'(sz),
				ffha_pkg::OFFSET_W'($urandom));
		end else if (pick < 88 && live_offsets.size() != 0) begin
			free_live($urandom_range(live_offsets.size() - 1));
		end else if (pick < 94 && stale_offsets.size() != 0) begin
			issue_request(ffha_pkg::MODE_FREE, ffha_pkg::SIZE_W'($urandom),
				ffha_pkg::OFFSET_W'(stale_offsets[$urandom_range(stale_offsets.size() - 1)]));
		end else begin
			issue_request(ffha_pkg::MODE_FREE, ffha_pkg::SIZE_W'($urandom),
				ffha_pkg::OFFSET_W'($urandom));
		end
	endtask

	// ---------------- tests ----------------

	// Allocate edge cases on a one-page heap: zero size, exact fit of the
	// whole heap, no split when the tail is too small, no fit at full size.
	task automatic test_directed_alloc();
		write_pages(1);
		issue_request(ffha_pkg::MODE_ALLOC, 16'd0, 16'hFFFF);
		issue_request(ffha_pkg::MODE_ALLOC, 16'hFFFF, 16'd0);
		issue_request(ffha_pkg::MODE_ALLOC, 16'd4072, 16'd0);   // whole heap
		issue_request(ffha_pkg::MODE_ALLOC, 16'd1, 16'd0);      // heap is full
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd24);
		issue_request(ffha_pkg::MODE_ALLOC, 16'd4048, 16'd0);   // tail of 3 granules not split off
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd24);
		issue_request(ffha_pkg::MODE_ALLOC, 16'd1, 16'd0);      // split, rounds up
		issue_request(ffha_pkg::MODE_ALLOC, 16'd8, 16'd0);
		issue_request(ffha_pkg::MODE_ALLOC, 16'd9, 16'd0);
		live_offsets.delete();
	endtask

	// Free checks: misaligned, below the header, beyond the heap, double free,
	// merges on both sides, then a stale header inside a merged block.
	task automatic test_directed_free();
		write_pages(16);
		issue_request(ffha_pkg::MODE_ALLOC, 16'd40, 16'd0);  // 24
		issue_request(ffha_pkg::MODE_ALLOC, 16'd40, 16'd0);  // 88
		issue_request(ffha_pkg::MODE_ALLOC, 16'd40, 16'd0);  // 152
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd25);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd16);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd0);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'hFFF8);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd65520);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd88);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd88);   // double free
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd24);   // merges with next
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd152);  // merges with previous
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd88);   // stale header
		live_offsets.delete();
		write_pages(1);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd4096 + 16'd24);  // past one page
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd4088);           // header in range
	endtask

	// Register extremes, including zero and above the page limit.
	task automatic test_config_sweep();
		write_pages(0);
		issue_request(ffha_pkg::MODE_ALLOC, 16'd65000, 16'd0);
		write_pages(31);
		issue_request(ffha_pkg::MODE_ALLOC, 16'd65535, 16'd0);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd24);
		write_pages(17);
		issue_request(ffha_pkg::MODE_FREE, 16'd0, 16'd24);
		write_pages(16);
	endtask

	// Hold off the result side while requests keep coming, then pause the
	// sender until every result has arrived.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_cycles   = 400;
		repeat (20) random_item();
		drain_results();
		repeat (10) random_item();
	endtask

	task automatic test_random(int unsigned count);
		int unsigned idle_set[4];
		int unsigned stall_set[4];
		idle_set  = '{0, 76, 0, 38};
		stall_set = '{0, 0, 76, 38};
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				1:       write_pages(1);
				2:       write_pages(16);
				3:       write_pages($urandom_range(15, 2));
				default: ;
			endcase
			send_idle_pct = idle_set[ph];
			stall_pct     = stall_set[ph];
			repeat (count / 8) random_item();
			send_idle_pct = 0;
			stall_pct     = 0;
			repeat (count / 16) random_item();
			send_idle_pct = idle_set[ph];
			stall_pct     = stall_set[ph];
			repeat (count / 8) random_item();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		heap_pages    = '0;
		in_valid      = 1'b0;
		mode          = ffha_pkg::MODE_ALLOC;
		request_size  = '0;
		user_offset   = '0;
		out_stall     = 1'b0;
		cycles        = 0;
		errors        = 0;
		n_items       = 0;
		n_allocs_ok   = 0;
		n_frees_ok    = 0;
		n_rejects     = 0;
		n_cfg         = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_cycles   = 0;
		pages_reg     = ffha_pkg::RESET_PAGES;
		heap_reinit();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_directed_alloc();
		test_directed_free();
		test_config_sweep();
		test_backpressure();
		test_random(1200);
		test_backpressure();
		drain_results();

		$display("Covered %0d requests: %0d allocations, %0d frees, %0d rejected.",
			n_items, n_allocs_ok, n_frees_ok, n_rejects);
		$display("Heap was reconfigured %0d times across four idle/stall mixes.", n_cfg);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
